>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`define ASSERT_AFTER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/pfa_pkg.sv
package pfa_pkg;

   // Fixed widths of the ports.
   localparam int FUNC_W   = 2;
   localparam int FRAME_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_FRAMES = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_INIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic init_start;
      logic init_step;
      logic exec_op;
      logic init_finish;
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } stat_type;

endpackage

>>> rtl/pfa_ram.sv
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/pfa_ctrl.sv
module pfa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pfa_pkg::FUNC_W-1:0]    req_func,
   input  pfa_pkg::stat_type             stat,
   output logic                          busy,
   output pfa_pkg::cmd_type              cmd
);

   pfa_pkg::state_type state_ff;
   pfa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         pfa_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               if (req_func == pfa_pkg::FUNC_INIT) begin
                  cmd.init_start = 1'b1;
                  state_in       = pfa_pkg::ST_INIT;
               end else begin
                  state_in = pfa_pkg::ST_ACCESS;
               end
            end
         end
         pfa_pkg::ST_ACCESS: begin
            cmd.exec_op = 1'b1;
            state_in    = pfa_pkg::ST_IDLE;
         end
         pfa_pkg::ST_INIT: begin
            if (stat.walk_done) begin
               cmd.init_finish = 1'b1;
               state_in        = pfa_pkg::ST_IDLE;
            end else begin
               cmd.init_step = 1'b1;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/pfa_datapath.sv
module pfa_datapath #(
   parameter int MAX_FRAMES = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pfa_pkg::cmd_type                 cmd,
   output pfa_pkg::stat_type                stat,
   input  logic [pfa_pkg::FUNC_W-1:0]       req_func,
   input  logic [pfa_pkg::FRAME_W-1:0]      req_frame_index,
   input  logic                             csr_write_enable,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfa_pkg::COUNT_W-1:0]      csr_write_data,
   output logic                             rsp_valid,
   output logic [pfa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pfa_pkg::FRAME_W-1:0]      rsp_granted_frame,
   output logic [pfa_pkg::COUNT_W-1:0]      rsp_free_count,
   output logic [pfa_pkg::COUNT_W-1:0]      rsp_used_count
);

   localparam int IDX_W  = $clog2(MAX_FRAMES);
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
   localparam int WIDE_W = (CNT_W > pfa_pkg::COUNT_W) ? CNT_W : pfa_pkg::COUNT_W;
   localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_FRAMES);
   localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_FRAMES);

   // Configuration registers.
   logic [pfa_pkg::COUNT_W-1:0] total_cfg_ff, total_cfg_in;
   logic [pfa_pkg::COUNT_W-1:0] reserved_cfg_ff, reserved_cfg_in;

   // Pool state.
   logic [CNT_W-1:0] active_frames_ff, active_frames_in;
   logic [CNT_W-1:0] active_reserved_ff, active_reserved_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] walk_ff, walk_in;

   // Captured request.
   logic [pfa_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [pfa_pkg::FRAME_W-1:0] idx_ff, idx_in;

   // Result registers.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pfa_pkg::FRAME_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [pfa_pkg::COUNT_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [pfa_pkg::COUNT_W-1:0]   rsp_used_ff, rsp_used_in;

   // Memory ports.
   logic             stack_we;
   logic [IDX_W-1:0] stack_waddr, stack_wdata, stack_raddr, stack_rdata;
   logic             inuse_we;
   logic [IDX_W-1:0] inuse_waddr, inuse_raddr;
   logic             inuse_wdata, inuse_rdata;

   // Working values.
   logic [WIDE_W-1:0] total_wide, reserved_wide, clamp_n, clamp_r;
   logic [WIDE_W-1:0] idx_wide, req_idx_wide, pop_wide, depth_wide, used_wide;
   logic [WIDE_W-1:0] active_frames_wide, active_reserved_wide;
   logic [CNT_W-1:0]  depth_dec, walk_off;
   logic              walk_is_res, release_ok;

   pfa_ram #(.WIDTH(IDX_W), .DEPTH(MAX_FRAMES)) u_stack_ram (
      .clock (clock),
      .we    (stack_we),
      .waddr (stack_waddr),
      .wdata (stack_wdata),
      .raddr (stack_raddr),
      .rdata (stack_rdata)
   );

   pfa_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_inuse_ram (
      .clock (clock),
      .we    (inuse_we),
      .waddr (inuse_waddr),
      .wdata (inuse_wdata),
      .raddr (inuse_raddr),
      .rdata (inuse_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         total_cfg_ff       <= '0;
         reserved_cfg_ff    <= '0;
         active_frames_ff   <= '0;
         active_reserved_ff <= '0;
         depth_ff           <= '0;
         used_ff            <= '0;
         walk_ff            <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         total_cfg_ff       <= total_cfg_in;
         reserved_cfg_ff    <= reserved_cfg_in;
         active_frames_ff   <= active_frames_in;
         active_reserved_ff <= active_reserved_in;
         depth_ff           <= depth_in;
         used_ff            <= used_in;
         walk_ff            <= walk_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      func_ff        <= func_in;
      idx_ff         <= idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_used_ff    <= rsp_used_in;
   end

   always_comb begin
      total_cfg_in    = total_cfg_ff;
      reserved_cfg_in = reserved_cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pfa_pkg::CSR_TOTAL_FRAMES:    total_cfg_in    = csr_write_data;
            pfa_pkg::CSR_RESERVED_FRAMES: reserved_cfg_in = csr_write_data;
            default: begin
               total_cfg_in = total_cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      // Clamp the frame count to the pool size and the reserve to the frame count.
      total_wide    = WIDE_W'(total_cfg_ff);
      reserved_wide = WIDE_W'(reserved_cfg_ff);
      clamp_n       = (total_wide > MAX_WIDE) ? MAX_WIDE : total_wide;
      clamp_r       = (reserved_wide > clamp_n) ? clamp_n : reserved_wide;

      idx_wide             = WIDE_W'(idx_ff);
      req_idx_wide         = WIDE_W'(req_frame_index);
      active_frames_wide   = WIDE_W'(active_frames_ff);
      active_reserved_wide = WIDE_W'(active_reserved_ff);
      pop_wide             = WIDE_W'(stack_rdata);
      depth_dec            = depth_ff - CNT_W'(1);
      walk_off             = walk_ff - active_reserved_ff;
      walk_is_res          = (walk_ff < active_reserved_ff);

      release_ok = (idx_wide < active_frames_wide) && (idx_wide >= active_reserved_wide) &&
                   inuse_rdata && (depth_ff < MAX_CNT);

      // Reads are issued as the word is taken, so the registered read data is ready in the next cycle.
      stack_raddr = depth_dec[IDX_W-1:0];
      inuse_raddr = req_idx_wide[IDX_W-1:0];

      stack_we    = 1'b0;
      stack_waddr = depth_ff[IDX_W-1:0];
      stack_wdata = idx_wide[IDX_W-1:0];
      inuse_we    = 1'b0;
      inuse_waddr = idx_wide[IDX_W-1:0];
      inuse_wdata = 1'b0;

      active_frames_in   = active_frames_ff;
      active_reserved_in = active_reserved_ff;
      depth_in           = depth_ff;
      used_in            = used_ff;
      walk_in            = walk_ff;
      func_in            = func_ff;
      idx_in             = idx_ff;

      rsp_valid_in   = 1'b0;
      rsp_status_in  = pfa_pkg::STATUS_IGNORED;
      rsp_granted_in = '0;

      if (cmd.capture) begin
         func_in = req_func;
         idx_in  = req_frame_index;
      end

      if (cmd.init_start) begin
         active_frames_in   = clamp_n[CNT_W-1:0];
         active_reserved_in = clamp_r[CNT_W-1:0];
         depth_in           = '0;
         used_in            = '0;
         walk_in            = '0;
      end

      // One frame per cycle: reserved frames are marked in use, the rest pushed.
      if (cmd.init_step) begin
         inuse_we    = 1'b1;
         inuse_waddr = walk_ff[IDX_W-1:0];
         inuse_wdata = walk_is_res;
         if (walk_is_res) begin
            used_in = used_ff + CNT_W'(1);
         end else begin
            stack_we    = 1'b1;
            stack_waddr = walk_off[IDX_W-1:0];
            stack_wdata = walk_ff[IDX_W-1:0];
            depth_in    = depth_ff + CNT_W'(1);
         end
         walk_in = walk_ff + CNT_W'(1);
      end

      if (cmd.init_finish) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pfa_pkg::STATUS_DONE;
      end

      if (cmd.exec_op) begin
         rsp_valid_in = 1'b1;
         case (func_ff)
            pfa_pkg::FUNC_ALLOC: begin
               if (depth_ff == '0) begin
                  rsp_status_in = pfa_pkg::STATUS_EMPTY;
               end else begin
                  inuse_we       = 1'b1;
                  inuse_waddr    = stack_rdata;
                  inuse_wdata    = 1'b1;
                  depth_in       = depth_dec;
                  used_in        = used_ff + CNT_W'(1);
                  rsp_status_in  = pfa_pkg::STATUS_DONE;
                  rsp_granted_in = pop_wide[pfa_pkg::FRAME_W-1:0];
               end
            end
            pfa_pkg::FUNC_RELEASE: begin
               if (release_ok) begin
                  inuse_we      = 1'b1;
                  inuse_wdata   = 1'b0;
                  stack_we      = 1'b1;
                  depth_in      = depth_ff + CNT_W'(1);
                  used_in       = (used_ff != '0) ? used_ff - CNT_W'(1) : used_ff;
                  rsp_status_in = pfa_pkg::STATUS_DONE;
               end
            end
            default: begin
               rsp_status_in = pfa_pkg::STATUS_IGNORED;
            end
         endcase
      end

      depth_wide  = WIDE_W'(depth_in);
      used_wide   = WIDE_W'(used_in);
      rsp_free_in = depth_wide[pfa_pkg::COUNT_W-1:0];
      rsp_used_in = used_wide[pfa_pkg::COUNT_W-1:0];

      stat.walk_done = (walk_ff == active_frames_ff);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_frame = rsp_granted_ff;
   assign rsp_free_count    = rsp_free_ff;
   assign rsp_used_count    = rsp_used_ff;

endmodule

>>> rtl/page_frame_free_list_allocator.sv
// Channel        | Ports                                        | Handshake
// ---------------+----------------------------------------------+------------------------------
// request        | req_func, req_frame_index                    | taken when start & !busy
// response       | rsp_status, rsp_granted_frame,               | rsp_valid strobe, one cycle
//                | rsp_free_count, rsp_used_count               |
// configuration  | csr_index, csr_write_data                    | written when csr_write_enable
//
// For an allocate or release word, the stack or in-use memory is read through its registered
// port in the cycle the word is taken, and the update is made in the next cycle.
// An init word walks the pool over the clamped frame count, one frame a cycle, because there is one
// write port per memory. The response strobe follows in the cycle after the walk is seen to be done.
// Reset is synchronous and active high; it empties the pool and clears both registers.
// The memories are not cleared; only entries written since an init are ever used.
// The receiver cannot stall, so each response is shown for exactly one cycle.
module page_frame_free_list_allocator #(
   parameter int MAX_FRAMES = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [pfa_pkg::FUNC_W-1:0]      req_func,
   input  logic [pfa_pkg::FRAME_W-1:0]     req_frame_index,
   input  logic                            csr_write_enable,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::COUNT_W-1:0]     csr_write_data,
   output logic                            rsp_valid,
   output logic [pfa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [pfa_pkg::FRAME_W-1:0]     rsp_granted_frame,
   output logic [pfa_pkg::COUNT_W-1:0]     rsp_free_count,
   output logic [pfa_pkg::COUNT_W-1:0]     rsp_used_count
);

   // Commands from the controller and the walk status back from the datapath.
   pfa_pkg::cmd_type  cmd;
   pfa_pkg::stat_type stat;

   // The controller sequences a word: capture, then either the access state
   // or the init walk, followed by the response.
   pfa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // The datapath holds the registers, the counters, the free stack and the in-use flags.
   pfa_datapath #(.MAX_FRAMES(MAX_FRAMES)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_frame_index   (req_frame_index),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_granted_frame (rsp_granted_frame),
      .rsp_free_count    (rsp_free_count),
      .rsp_used_count    (rsp_used_count)
   );

endmodule

>>> rtl/pfa_checker.sv
`include "assert_macros.svh"

module pfa_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [pfa_pkg::FUNC_W-1:0]     req_func,
   input logic                           rsp_valid,
   input logic [pfa_pkg::STATUS_W-1:0]   rsp_status,
   input logic [pfa_pkg::FRAME_W-1:0]    rsp_granted_frame,
   input logic [pfa_pkg::COUNT_W-1:0]    rsp_free_count
);

   logic taken;
   logic taken_access;

   assign taken        = start && !busy;
   assign taken_access = taken && (req_func != pfa_pkg::FUNC_INIT);

   // A response is only shown once the block has gone idle again.
   `ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)

   // A taken word keeps the block busy in the following cycle.
   `ASSERT_NEXT(a_busy_after_take, clock, reset, taken, busy)

   // Allocate and release words answer once the result of the access state is registered.
   `ASSERT_AFTER2(a_access_latency, clock, reset, taken_access, rsp_valid)

   // Only a successful allocate carries a frame number.
   `ASSERT_IMPLY(a_grant_zero, clock, reset, rsp_valid && (rsp_status != pfa_pkg::STATUS_DONE),
      rsp_granted_frame == '0)

   // An exhausted pool reports an empty free list.
   `ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid && (rsp_status == pfa_pkg::STATUS_EMPTY),
      rsp_free_count == '0)

endmodule

bind page_frame_free_list_allocator pfa_assertions u_pfa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_func          (req_func),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_granted_frame (rsp_granted_frame),
   .rsp_free_count    (rsp_free_count)
);
